// File: hdl/amir_pkg.sv
// Shared types, codes and microprogram of the area moment interaction row unit.
`timescale 1ns / 1ps
`default_nettype none
package amir_pkg;

   localparam int AMIR_FRAC_BITS = 16;
   localparam int NUM_SLOTS      = 13;
   localparam int RF_DEPTH       = 37;
   localparam int PC_WIDTH       = 7;
   localparam int SRC_WIDTH      = 6;

   typedef logic [SRC_WIDTH-1:0] src_type;
   typedef logic [PC_WIDTH-1:0]  pc_type;

   typedef enum logic [3:0] {
      OP_MUL   = 4'd0,
      OP_ADD   = 4'd1,
      OP_SUB   = 4'd2,
      OP_DIV   = 4'd3,
      OP_TSTZ  = 4'd4,
      OP_JERR  = 4'd5,
      OP_JDISC = 4'd6,
      OP_JMP   = 4'd7,
      OP_OUT   = 4'd8
   } opcode_type;

   localparam logic [2:0] COL_VX = 3'd0;
   localparam logic [2:0] COL_VY = 3'd1;
   localparam logic [2:0] COL_VZ = 3'd2;
   localparam logic [2:0] COL_WX = 3'd3;
   localparam logic [2:0] COL_WY = 3'd4;
   localparam logic [2:0] COL_WZ = 3'd5;

   localparam logic [1:0] CSR_PLANE_A  = 2'd0;
   localparam logic [1:0] CSR_PLANE_B  = 2'd1;
   localparam logic [1:0] CSR_PLANE_C  = 2'd2;
   localparam logic [1:0] CSR_DISCRETE = 2'd3;

   // moment slots
   localparam src_type S_M00  = 6'd0;
   localparam src_type S_MU10 = 6'd1;
   localparam src_type S_MU01 = 6'd2;
   localparam src_type S_MU11 = 6'd3;
   localparam src_type S_MU20 = 6'd4;
   localparam src_type S_MU02 = 6'd5;
   localparam src_type S_MU21 = 6'd6;
   localparam src_type S_MU12 = 6'd7;
   localparam src_type S_MU30 = 6'd8;
   localparam src_type S_MU03 = 6'd9;
   localparam src_type S_XG   = 6'd10;
   localparam src_type S_YG   = 6'd11;
   localparam src_type S_AN   = 6'd12;
   // scratch registers
   localparam src_type R_XN  = 6'd13;
   localparam src_type R_YN  = 6'd14;
   localparam src_type R_TA  = 6'd15;
   localparam src_type R_N11 = 6'd16;
   localparam src_type R_N20 = 6'd17;
   localparam src_type R_N02 = 6'd18;
   localparam src_type R_E01 = 6'd19;
   localparam src_type R_E10 = 6'd20;
   localparam src_type R_E11 = 6'd21;
   localparam src_type R_E02 = 6'd22;
   localparam src_type R_E20 = 6'd23;
   localparam src_type R_E12 = 6'd24;
   localparam src_type R_E21 = 6'd25;
   localparam src_type R_E03 = 6'd26;
   localparam src_type R_E30 = 6'd27;
   localparam src_type R_T1  = 6'd28;
   localparam src_type R_T2  = 6'd29;
   localparam src_type R_T3  = 6'd30;
   localparam src_type R_T4  = 6'd31;
   localparam src_type R_V0  = 6'd32;
   localparam src_type R_V1  = 6'd33;
   localparam src_type R_V2  = 6'd34;
   localparam src_type R_V3  = 6'd35;
   localparam src_type R_V4  = 6'd36;
   // operand sources outside the register file
   localparam src_type S_CA    = 6'd48;
   localparam src_type S_CB    = 6'd49;
   localparam src_type S_CC    = 6'd50;
   localparam src_type S_ZERO  = 6'd51;
   localparam src_type S_HALF  = 6'd52;
   localparam src_type S_3HALF = 6'd53;
   localparam src_type S_TWO   = 6'd54;
   localparam src_type S_MONE  = 6'd55;

   localparam pc_type L_DISC = 7'd23;
   localparam pc_type L_OUT  = 7'd71;
   localparam pc_type L_ERR  = 7'd77;

   typedef struct packed {
      logic [3:0]         slot;
      logic signed [31:0] moment_value;
      logic               final_item;
   } req_type;

   typedef struct packed {
      logic [2:0]         column;
      logic signed [31:0] row_value;
      logic               row_end;
      logic               divide_error;
   } rsp_type;

   typedef struct packed {
      logic signed [31:0] plane_a;
      logic signed [31:0] plane_b;
      logic signed [31:0] plane_c;
      logic               discrete_mode;
   } cfg_type;

   typedef struct packed {
      opcode_type op;
      src_type    dst;
      src_type    src_a;
      src_type    src_b;
      pc_type     target;
      logic [2:0] column;
      logic       last;
   } ucode_type;

   typedef struct packed {
      logic      rd;
      logic      wr_alu;
      logic      div_start;
      logic      wr_div;
      logic      tst;
      logic      clr_err;
      logic      out_load;
      ucode_type word;
   } ctrl_type;

   typedef struct packed {
      logic err;
      logic div_done;
      logic out_free;
   } stat_type;

   function automatic ucode_type mk(opcode_type op, src_type dst, src_type a, src_type b);
      ucode_type w;
      w        = '0;
      w.op     = op;
      w.dst    = dst;
      w.src_a  = a;
      w.src_b  = b;
      return w;
   endfunction

   function automatic ucode_type mkj(opcode_type op, pc_type target);
      ucode_type w;
      w        = '0;
      w.op     = op;
      w.src_a  = S_ZERO;
      w.src_b  = S_ZERO;
      w.target = target;
      return w;
   endfunction

   function automatic ucode_type mko(src_type a, logic [2:0] column, logic last);
      ucode_type w;
      w        = '0;
      w.op     = OP_OUT;
      w.src_a  = a;
      w.src_b  = S_ZERO;
      w.column = column;
      w.last   = last;
      return w;
   endfunction

   function automatic ucode_type rom_word(pc_type pc);
      ucode_type w;
      case (pc)
         7'd0:  w = mk(OP_MUL, R_XN, S_AN, S_XG);
         7'd1:  w = mk(OP_MUL, R_YN, S_AN, S_YG);
         7'd2:  w = mk(OP_ADD, R_TA, S_MU20, S_MU02);
         7'd3:  w = mk(OP_TSTZ, R_T1, S_M00, S_ZERO);
         7'd4:  w = mk(OP_TSTZ, R_T1, R_TA, S_ZERO);
         7'd5:  w = mkj(OP_JERR, L_ERR);
         7'd6:  w = mkj(OP_JDISC, L_DISC);
         // dense object
         7'd7:  w = mk(OP_MUL, R_T1, S_CA, S_AN);
         7'd8:  w = mk(OP_MUL, R_V0, R_T1, S_HALF);
         7'd9:  w = mk(OP_MUL, R_T1, S_CB, S_AN);
         7'd10: w = mk(OP_MUL, R_V1, R_T1, S_HALF);
         7'd11: w = mk(OP_MUL, R_T1, S_AN, S_CC);
         7'd12: w = mk(OP_SUB, R_T1, S_ZERO, R_T1);
         7'd13: w = mk(OP_MUL, R_T2, S_3HALF, S_CA);
         7'd14: w = mk(OP_MUL, R_T2, R_T2, R_XN);
         7'd15: w = mk(OP_SUB, R_T1, R_T1, R_T2);
         7'd16: w = mk(OP_MUL, R_T2, S_3HALF, S_CB);
         7'd17: w = mk(OP_MUL, R_T2, R_T2, R_YN);
         7'd18: w = mk(OP_SUB, R_V2, R_T1, R_T2);
         7'd19: w = mk(OP_MUL, R_T1, S_3HALF, R_YN);
         7'd20: w = mk(OP_SUB, R_V3, S_ZERO, R_T1);
         7'd21: w = mk(OP_MUL, R_V4, S_3HALF, R_XN);
         7'd22: w = mkj(OP_JMP, L_OUT);
         // discrete point set
         7'd23: w = mk(OP_DIV, R_N11, S_MU11, S_M00);
         7'd24: w = mk(OP_DIV, R_N20, S_MU20, S_M00);
         7'd25: w = mk(OP_DIV, R_N02, S_MU02, S_M00);
         7'd26: w = mk(OP_DIV, R_E01, S_MU01, R_TA);
         7'd27: w = mk(OP_DIV, R_E10, S_MU10, R_TA);
         7'd28: w = mk(OP_DIV, R_E11, S_MU11, R_TA);
         7'd29: w = mk(OP_DIV, R_E02, S_MU02, R_TA);
         7'd30: w = mk(OP_DIV, R_E20, S_MU20, R_TA);
         7'd31: w = mk(OP_DIV, R_E12, S_MU12, R_TA);
         7'd32: w = mk(OP_DIV, R_E21, S_MU21, R_TA);
         7'd33: w = mk(OP_DIV, R_E03, S_MU03, R_TA);
         7'd34: w = mk(OP_DIV, R_E30, S_MU30, R_TA);
         7'd35: w = mk(OP_MUL, R_T1, S_AN, S_CA);
         7'd36: w = mk(OP_MUL, R_T2, S_AN, S_CB);
         7'd37: w = mk(OP_MUL, R_T3, R_T1, R_E20);
         7'd38: w = mk(OP_MUL, R_T4, R_T2, R_E11);
         7'd39: w = mk(OP_ADD, R_V0, R_T3, R_T4);
         7'd40: w = mk(OP_MUL, R_T3, R_T1, R_E11);
         7'd41: w = mk(OP_MUL, R_T4, R_T2, R_E02);
         7'd42: w = mk(OP_ADD, R_V1, R_T3, R_T4);
         7'd43: w = mk(OP_MUL, R_T1, R_N02, R_E01);
         7'd44: w = mk(OP_MUL, R_T2, R_N11, R_E10);
         7'd45: w = mk(OP_ADD, R_T1, R_T1, R_T2);
         7'd46: w = mk(OP_SUB, R_T1, R_T1, R_E03);
         7'd47: w = mk(OP_SUB, R_T1, R_T1, R_E21);
         7'd48: w = mk(OP_MUL, R_T1, R_T1, S_AN);
         7'd49: w = mk(OP_MUL, R_T2, R_XN, R_E11);
         7'd50: w = mk(OP_SUB, R_T1, R_T1, R_T2);
         7'd51: w = mk(OP_SUB, R_T2, S_MONE, R_E02);
         7'd52: w = mk(OP_MUL, R_T2, R_T2, R_YN);
         7'd53: w = mk(OP_ADD, R_V3, R_T1, R_T2);
         7'd54: w = mk(OP_ADD, R_T1, R_E12, R_E30);
         7'd55: w = mk(OP_MUL, R_T2, R_N11, R_E01);
         7'd56: w = mk(OP_SUB, R_T1, R_T1, R_T2);
         7'd57: w = mk(OP_MUL, R_T2, R_N20, R_E10);
         7'd58: w = mk(OP_SUB, R_T1, R_T1, R_T2);
         7'd59: w = mk(OP_MUL, R_T1, R_T1, S_AN);
         7'd60: w = mk(OP_SUB, R_T2, S_TWO, R_E02);
         7'd61: w = mk(OP_MUL, R_T2, R_T2, R_XN);
         7'd62: w = mk(OP_ADD, R_T1, R_T1, R_T2);
         7'd63: w = mk(OP_MUL, R_T2, R_YN, R_E11);
         7'd64: w = mk(OP_ADD, R_V4, R_T1, R_T2);
         7'd65: w = mk(OP_MUL, R_T1, S_AN, S_CC);
         7'd66: w = mk(OP_SUB, R_T1, S_ZERO, R_T1);
         7'd67: w = mk(OP_MUL, R_T2, S_CB, R_V3);
         7'd68: w = mk(OP_ADD, R_T1, R_T1, R_T2);
         7'd69: w = mk(OP_MUL, R_T2, S_CA, R_V4);
         7'd70: w = mk(OP_SUB, R_V2, R_T1, R_T2);
         // emit row
         7'd71: w = mko(R_V0, COL_VX, 1'b0);
         7'd72: w = mko(R_V1, COL_VY, 1'b0);
         7'd73: w = mko(R_V2, COL_VZ, 1'b0);
         7'd74: w = mko(R_V3, COL_WX, 1'b0);
         7'd75: w = mko(R_V4, COL_WY, 1'b0);
         7'd76: w = mko(S_ZERO, COL_WZ, 1'b1);
         // zero divisor
         7'd77: w = mko(S_ZERO, COL_VX, 1'b0);
         7'd78: w = mko(S_ZERO, COL_VY, 1'b0);
         7'd79: w = mko(S_ZERO, COL_VZ, 1'b0);
         7'd80: w = mko(S_ZERO, COL_WX, 1'b0);
         7'd81: w = mko(S_ZERO, COL_WY, 1'b0);
         7'd82: w = mko(S_ZERO, COL_WZ, 1'b1);
         default: w = mkj(OP_JMP, L_ERR);
      endcase
      return w;
   endfunction

endpackage
`default_nettype wire

// File: hdl/area_moment_interaction_row_unit.sv
// A non-final item is only stored; a final item is stored and then runs the microprogram.
// Dense mode needs no divide; discrete mode adds twelve divides
// on the shared radix-2 divider.
// Each microcode step has an operand read state and then an execute state; six results follow.
// One item at a time; a new item is taken once the sixth result is issued.
// Reset is synchronous: moment store reads as zero, plane_c resets to 1.0, others to 0.
`timescale 1ns / 1ps
`default_nettype none
module area_moment_interaction_row_unit #(
   parameter int FRAC_BITS = amir_pkg::AMIR_FRAC_BITS
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  amir_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output amir_pkg::rsp_type  rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [31:0]       csr_wdata
);
   import amir_pkg::*;

   cfg_type  cfg_ff, cfg_in;
   ctrl_type ctrl;
   stat_type stat;
   logic     idle, req_take, start, load_en;

   assign csr_ready = 1'b1;
   assign req_stall = !idle;
   assign req_take  = req_valid && !req_stall;
   assign start     = req_take && req_data.final_item;
   assign load_en   = req_take && (req_data.slot < 4'(NUM_SLOTS));

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_PLANE_A:  cfg_in.plane_a       = csr_wdata;
            CSR_PLANE_B:  cfg_in.plane_b       = csr_wdata;
            CSR_PLANE_C:  cfg_in.plane_c       = csr_wdata;
            CSR_DISCRETE: cfg_in.discrete_mode = csr_wdata[0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.plane_a       <= '0;
         cfg_ff.plane_b       <= '0;
         cfg_ff.plane_c       <= 32'(1) << FRAC_BITS;
         cfg_ff.discrete_mode <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   amir_sequencer u_seq (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .discrete_mode (cfg_ff.discrete_mode),
      .stat          (stat),
      .ctrl          (ctrl),
      .idle          (idle)
   );

   amir_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .ctrl       (ctrl),
      .load_en    (load_en),
      .load_slot  (req_data.slot),
      .load_value (req_data.moment_value),
      .stat       (stat),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

`ifndef SYNTH
   a_busy_after_final: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_data.final_item) |=> req_stall)
      else $error("input taken during evaluation");
   a_row_closed: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_data.row_end) |=>
      (!rsp_valid || (rsp_data.column == COL_VX)))
      else $error("result issued after row end");
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.divide_error) |-> (rsp_data.row_value == 32'sd0))
      else $error("nonzero value with divide error");
`endif
endmodule
`default_nettype wire

// File: hdl/amir_div.sv
// Radix-2 signed fixed-point divider with saturation.
`timescale 1ns / 1ps
`default_nettype none
module amir_div #(
   parameter int FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [31:0] num,
   input  logic signed [31:0] den,
   output logic               done,
   output logic signed [31:0] quo
);
   localparam int NW = 32 + FRAC_BITS;
   localparam int CW = $clog2(NW + 1);
   localparam logic [NW-1:0] POS_LIM = NW'(64'h7fffffff);
   localparam logic [NW-1:0] NEG_LIM = NW'(64'h80000000);

   logic          busy_ff, busy_in, fin_ff, fin_in;
   logic          neg_ff, neg_in, dz_ff, dz_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [NW-1:0] dq_ff, dq_in;
   logic [32:0]   rem_ff, rem_in, rem_sh;
   logic [31:0]   dm_ff, dm_in, nmag, dmag;

   always_comb begin
      nmag    = num[31] ? (~num + 32'd1) : num;
      dmag    = den[31] ? (~den + 32'd1) : den;
      rem_sh  = {rem_ff[31:0], dq_ff[NW-1]};
      busy_in = busy_ff;
      fin_in  = 1'b0;
      neg_in  = neg_ff;
      dz_in   = dz_ff;
      cnt_in  = cnt_ff;
      dq_in   = dq_ff;
      rem_in  = rem_ff;
      dm_in   = dm_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         dq_in   = {nmag, {FRAC_BITS{1'b0}}};
         dm_in   = dmag;
         neg_in  = num[31] ^ den[31];
         dz_in   = (den == 32'sd0);
      end else if (busy_ff) begin
         if (rem_sh >= {1'b0, dm_ff}) begin
            rem_in = rem_sh - {1'b0, dm_ff};
            dq_in  = {dq_ff[NW-2:0], 1'b1};
         end else begin
            rem_in = rem_sh;
            dq_in  = {dq_ff[NW-2:0], 1'b0};
         end
         cnt_in = cnt_ff + CW'(1);
         if (cnt_ff == CW'(NW - 1)) begin
            busy_in = 1'b0;
            fin_in  = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         fin_ff  <= fin_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff <= neg_in;
      dz_ff  <= dz_in;
      cnt_ff <= cnt_in;
      dq_ff  <= dq_in;
      rem_ff <= rem_in;
      dm_ff  <= dm_in;
   end

   always_comb begin
      done = fin_ff;
      if (dz_ff) begin
         quo = '0;
      end else if (!neg_ff) begin
         quo = (dq_ff > POS_LIM) ? 32'sh7fffffff : signed'(dq_ff[31:0]);
      end else begin
         quo = (dq_ff > NEG_LIM) ? 32'sh80000000 : signed'(~dq_ff[31:0] + 32'd1);
      end
   end
endmodule
`default_nettype wire

// File: hdl/amir_datapath.sv
// Register file, saturating ALU, divider and result register.
`timescale 1ns / 1ps
`default_nettype none
module amir_datapath #(
   parameter int FRAC_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  amir_pkg::cfg_type  cfg,
   input  amir_pkg::ctrl_type ctrl,
   input  logic              load_en,
   input  logic [3:0]        load_slot,
   input  logic [31:0]       load_value,
   output amir_pkg::stat_type stat,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output amir_pkg::rsp_type  rsp_data
);
   import amir_pkg::*;

   localparam logic [31:0] ONE_Q   = 32'(1) << FRAC_BITS;
   localparam logic [31:0] HALF_Q  = 32'(1) << (FRAC_BITS - 1);
   localparam logic [31:0] THREE_Q = 32'(3) << (FRAC_BITS - 1);
   localparam logic [31:0] TWO_Q   = 32'(2) << FRAC_BITS;
   localparam logic [31:0] MONE_Q  = ~ONE_Q + 32'd1;

   logic [31:0]          rf [RF_DEPTH];
   logic [NUM_SLOTS-1:0] valid_ff;
   logic [31:0]          rd_a_ff, rd_b_ff, spec_a_ff, spec_b_ff;
   logic                 use_a_ff, use_b_ff, zero_a_ff, zero_b_ff;
   logic                 err_ff, rsp_valid_ff;
   rsp_type              rsp_ff;
   logic signed [31:0]   opa, opb, alu_res, div_q;
   logic signed [32:0]   sum33, dif33;
   logic signed [63:0]   prod, shp;
   logic                 div_done, out_free;

   function automatic logic [31:0] spec_val(src_type s, cfg_type c);
      logic [31:0] v;
      case (s)
         S_CA:    v = c.plane_a;
         S_CB:    v = c.plane_b;
         S_CC:    v = c.plane_c;
         S_HALF:  v = HALF_Q;
         S_3HALF: v = THREE_Q;
         S_TWO:   v = TWO_Q;
         S_MONE:  v = MONE_Q;
         default: v = '0;
      endcase
      return v;
   endfunction

   function automatic logic signed [31:0] sat33(logic signed [32:0] v);
      if (v[32] != v[31]) return v[32] ? 32'sh80000000 : 32'sh7fffffff;
      return v[31:0];
   endfunction

   function automatic logic signed [31:0] sat64(logic signed [63:0] v);
      if (v[63:31] == '0 || v[63:31] == '1) return v[31:0];
      return v[63] ? 32'sh80000000 : 32'sh7fffffff;
   endfunction

   always_ff @(posedge clock) begin
      if (ctrl.rd) begin
         rd_a_ff   <= rf[ctrl.word.src_a];
         rd_b_ff   <= rf[ctrl.word.src_b];
         spec_a_ff <= spec_val(ctrl.word.src_a, cfg);
         spec_b_ff <= spec_val(ctrl.word.src_b, cfg);
         use_a_ff  <= (ctrl.word.src_a >= SRC_WIDTH'(RF_DEPTH));
         use_b_ff  <= (ctrl.word.src_b >= SRC_WIDTH'(RF_DEPTH));
         zero_a_ff <= (ctrl.word.src_a < SRC_WIDTH'(NUM_SLOTS)) && !valid_ff[ctrl.word.src_a[3:0]];
         zero_b_ff <= (ctrl.word.src_b < SRC_WIDTH'(NUM_SLOTS)) && !valid_ff[ctrl.word.src_b[3:0]];
      end
      if (load_en) begin
         rf[{2'b00, load_slot}] <= load_value;
      end else if (ctrl.wr_alu) begin
         rf[ctrl.word.dst] <= alu_res;
      end else if (ctrl.wr_div) begin
         rf[ctrl.word.dst] <= div_q;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (load_en) begin
         valid_ff[load_slot] <= 1'b1;
      end
   end

   always_comb begin
      opa   = use_a_ff ? spec_a_ff : (zero_a_ff ? '0 : rd_a_ff);
      opb   = use_b_ff ? spec_b_ff : (zero_b_ff ? '0 : rd_b_ff);
      sum33 = {opa[31], opa} + {opb[31], opb};
      dif33 = {opa[31], opa} - {opb[31], opb};
      prod  = 64'(opa) * 64'(opb);
      shp   = prod >>> FRAC_BITS;
      case (ctrl.word.op)
         OP_MUL:  alu_res = sat64(shp);
         OP_ADD:  alu_res = sat33(sum33);
         OP_SUB:  alu_res = sat33(dif33);
         default: alu_res = '0;
      endcase
   end

   amir_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clock (clock),
      .reset (reset),
      .start (ctrl.div_start),
      .num   (opa),
      .den   (opb),
      .done  (div_done),
      .quo   (div_q)
   );

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         err_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (ctrl.clr_err) begin
            err_ff <= 1'b0;
         end else if (ctrl.tst && opa == 32'sd0) begin
            err_ff <= 1'b1;
         end
         if (ctrl.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.out_load) begin
         rsp_ff.column       <= ctrl.word.column;
         rsp_ff.row_value    <= opa;
         rsp_ff.row_end      <= ctrl.word.last;
         rsp_ff.divide_error <= err_ff;
      end
   end

   assign stat.err      = err_ff;
   assign stat.div_done = div_done;
   assign stat.out_free = out_free;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_data      = rsp_ff;
endmodule
`default_nettype wire

// File: hdl/amir_sequencer.sv
// Step counter, microcode table and control state machine.
`timescale 1ns / 1ps
`default_nettype none
module amir_sequencer (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               discrete_mode,
   input  amir_pkg::stat_type  stat,
   output amir_pkg::ctrl_type  ctrl,
   output logic               idle
);
   import amir_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_READ = 4'b0010,
      ST_EXEC = 4'b0100,
      ST_DIVW = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   pc_type    pc_ff, pc_in, pc_next;
   ucode_type word;

   assign word    = rom_word(pc_ff);
   assign pc_next = pc_ff + PC_WIDTH'(1);

   always_comb begin
      state_in  = state_ff;
      pc_in     = pc_ff;
      ctrl      = '0;
      ctrl.word = word;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in     = ST_READ;
               pc_in        = '0;
               ctrl.clr_err = 1'b1;
            end
         end
         ST_READ: begin
            ctrl.rd  = 1'b1;
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            case (word.op)
               OP_MUL, OP_ADD, OP_SUB: begin
                  ctrl.wr_alu = 1'b1;
                  pc_in       = pc_next;
                  state_in    = ST_READ;
               end
               OP_TSTZ: begin
                  ctrl.tst = 1'b1;
                  pc_in    = pc_next;
                  state_in = ST_READ;
               end
               OP_DIV: begin
                  ctrl.div_start = 1'b1;
                  state_in       = ST_DIVW;
               end
               OP_JERR: begin
                  pc_in    = stat.err ? word.target : pc_next;
                  state_in = ST_READ;
               end
               OP_JDISC: begin
                  pc_in    = discrete_mode ? word.target : pc_next;
                  state_in = ST_READ;
               end
               OP_JMP: begin
                  pc_in    = word.target;
                  state_in = ST_READ;
               end
               OP_OUT: begin
                  if (stat.out_free) begin
                     ctrl.out_load = 1'b1;
                     pc_in         = pc_next;
                     state_in      = word.last ? ST_IDLE : ST_READ;
                  end
               end
               default: state_in = ST_IDLE;
            endcase
         end
         ST_DIVW: begin
            if (stat.div_done) begin
               ctrl.wr_div = 1'b1;
               pc_in       = pc_next;
               state_in    = ST_READ;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pc_ff    <= '0;
      end else begin
         state_ff <= state_in;
         pc_ff    <= pc_in;
      end
   end

   assign idle = (state_ff == ST_IDLE);
endmodule
`default_nettype wire

// File: verif/amir_row_checker.sv
// Row checker: watches the item and row channels, predicts each row and compares it.
`timescale 1ns / 1ps
module amir_row_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  amir_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  amir_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   input  logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [31:0]       csr_wdata,
   output int                fail_count,
   output int                rows_pending,
   output int                rows_seen
);
   import amir_pkg::*;

   localparam int FB = AMIR_FRAC_BITS;

   logic signed [31:0] moments [NUM_SLOTS];
   logic signed [31:0] pa, pb, pc;
   logic               disc;
   rsp_type            row_queue [$];

   function automatic logic signed [31:0] sat64(longint v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   function automatic logic signed [31:0] qa(logic signed [31:0] a, logic signed [31:0] b);
      return sat64(longint'(a) + longint'(b));
   endfunction

   function automatic logic signed [31:0] qs(logic signed [31:0] a, logic signed [31:0] b);
      return sat64(longint'(a) - longint'(b));
   endfunction

   function automatic logic signed [31:0] qn(logic signed [31:0] a);
      return sat64(-longint'(a));
   endfunction

   function automatic logic signed [31:0] qm(logic signed [31:0] a, logic signed [31:0] b);
      longint p;
      p = longint'(a) * longint'(b);
      return sat64(p >>> FB);
   endfunction

   function automatic logic signed [31:0] qd(logic signed [31:0] n, logic signed [31:0] d);
      longint q;
      if (d == 0) return 0;
      q = (longint'(n) * (64'sd1 << FB)) / longint'(d);
      return sat64(q);
   endfunction

   task automatic predict_row();
      logic signed [31:0] row [6];
      logic signed [31:0] half, thalf, one, two, an, xn, yn, a, t, wx, wy;
      logic signed [31:0] n11, n20, n02, e01, e10, e11, e02, e20, e12, e21, e03, e30;
      logic err;
      rsp_type r;
      half = 32'sd1 <<< (FB - 1);
      thalf = 32'sd3 <<< (FB - 1);
      one = 32'sd1 <<< FB;
      two = 32'sd2 <<< FB;
      foreach (row[k]) row[k] = 0;
      an = moments[12];
      xn = qm(an, moments[10]);
      yn = qm(an, moments[11]);
      a = qa(moments[4], moments[5]);
      err = (moments[0] == 0) || (a == 0);
      if (!err && disc) begin
         n11 = qd(moments[3], moments[0]);
         n20 = qd(moments[4], moments[0]);
         n02 = qd(moments[5], moments[0]);
         e01 = qd(moments[2], a);
         e10 = qd(moments[1], a);
         e11 = qd(moments[3], a);
         e02 = qd(moments[5], a);
         e20 = qd(moments[4], a);
         e12 = qd(moments[7], a);
         e21 = qd(moments[6], a);
         e03 = qd(moments[9], a);
         e30 = qd(moments[8], a);
         row[0] = qa(qm(qm(an, pa), e20), qm(qm(an, pb), e11));
         row[1] = qa(qm(qm(an, pa), e11), qm(qm(an, pb), e02));
         t = qs(qs(qa(qm(n02, e01), qm(n11, e10)), e03), e21);
         wx = qa(qs(qm(t, an), qm(xn, e11)), qm(qs(qn(one), e02), yn));
         t = qs(qs(qa(e12, e30), qm(n11, e01)), qm(n20, e10));
         wy = qa(qa(qm(t, an), qm(qs(two, e02), xn)), qm(yn, e11));
         row[2] = qs(qa(qn(qm(an, pc)), qm(pb, wx)), qm(pa, wy));
         row[3] = wx;
         row[4] = wy;
      end else if (!err) begin
         row[0] = qm(qm(pa, an), half);
         row[1] = qm(qm(pb, an), half);
         row[2] = qs(qs(qn(qm(an, pc)), qm(qm(thalf, pa), xn)), qm(qm(thalf, pb), yn));
         row[3] = qn(qm(thalf, yn));
         row[4] = qm(thalf, xn);
      end
      for (int k = 0; k < 6; k++) begin
         r.column = k[2:0];
         r.row_value = row[k];
         r.row_end = (k == 5);
         r.divide_error = err;
         row_queue.push_back(r);
      end
   endtask

   task automatic report_mismatch(string what, longint got, longint want);
      $display("MISMATCH %s: got %0h want %0h", what, got, want);
      fail_count++;
   endtask

   assign rows_pending = row_queue.size();

   initial begin
      fail_count = 0;
      rows_seen = 0;
   end

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         foreach (moments[i]) moments[i] = 0;
         pa = 0;
         pb = 0;
         pc = 32'sd65536;
         disc = 0;
         row_queue.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_PLANE_A:  pa = csr_wdata;
               CSR_PLANE_B:  pb = csr_wdata;
               CSR_PLANE_C:  pc = csr_wdata;
               CSR_DISCRETE: disc = csr_wdata[0];
               default:      disc = disc;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            rows_seen++;
            if (row_queue.size() == 0) begin
               report_mismatch("unexpected result", rsp_data, 0);
            end else begin
               want = row_queue.pop_front();
               if (rsp_data.column !== want.column)
                  report_mismatch("column", rsp_data.column, want.column);
               if (rsp_data.row_value !== want.row_value)
                  report_mismatch($sformatf("row_value col %0d", want.column),
                                  rsp_data.row_value, want.row_value);
               if (rsp_data.row_end !== want.row_end)
                  report_mismatch("row_end", rsp_data.row_end, want.row_end);
               if (rsp_data.divide_error !== want.divide_error)
                  report_mismatch("divide_error", rsp_data.divide_error, want.divide_error);
            end
         end
         if (req_valid && !req_stall) begin
            if (req_data.slot < NUM_SLOTS) moments[req_data.slot] = req_data.moment_value;
            if (req_data.final_item) predict_row();
         end
      end
   end
endmodule

// File: verif/testbench.sv
// Testbench top: drives moment items and plane settings, and gives the verdict.
`timescale 1ns / 1ps
module testbench;
   import amir_pkg::*;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   rsp_type     rsp_data;
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [31:0] csr_wdata;
   int          fail_count;
   int          rows_pending;
   int          rows_seen;
   int          cycle_count;
   int          items_sent;
   int          settings_used;

   localparam int CYCLE_LIMIT = 2000000;

   area_moment_interaction_row_unit i_dut (
      .clock, .reset, .req_valid, .req_stall, .req_data, .rsp_valid, .rsp_stall,
      .rsp_data, .csr_valid, .csr_ready, .csr_index, .csr_wdata
   );

   amir_row_checker i_checker (
      .clock, .reset, .req_valid, .req_stall, .req_data, .rsp_valid, .rsp_stall,
      .rsp_data, .csr_valid, .csr_ready, .csr_index, .csr_wdata,
      .fail_count, .rows_pending, .rows_seen
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("Some tests failed");
         $finish;
      end
   end

   function automatic int gap_len();
      if ($urandom_range(0, 9) < 7) return $urandom_range(0, 2);
      return $urandom_range(5, 60);
   endfunction

   logic stall_quiet;
   int   stall_left;
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= 1;
      end else if (!stall_quiet && $urandom_range(0, 3) == 0) begin
         stall_left <= gap_len();
         rsp_stall <= 1;
      end else begin
         rsp_stall <= 0;
      end
   end

   // valid stays high after an accepted item; a gap or a drain drops it
   task automatic send_item(logic [3:0] slot, logic [31:0] value, logic fin, bit gaps);
      int g;
      g = gaps ? gap_len() : 0;
      if (g > 0) begin
         req_valid <= 0;
         repeat (g) @(posedge clock);
      end
      req_valid <= 1;
      req_data <= '{slot: slot, moment_value: value, final_item: fin};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
   endtask

   task automatic drain();
      req_valid <= 0;
      @(posedge clock);
      while (rows_pending != 0) @(posedge clock);
      repeat (1000) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [31:0] value);
      csr_valid <= 1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic set_plane(logic [31:0] a, logic [31:0] b, logic [31:0] c, logic d);
      drain();
      write_csr(CSR_PLANE_A, a);
      write_csr(CSR_PLANE_B, b);
      write_csr(CSR_PLANE_C, c);
      write_csr(CSR_DISCRETE, {31'd0, d});
      csr_valid <= 0;
      settings_used++;
   endtask

   function automatic logic [31:0] rand_value();
      case ($urandom_range(0, 5))
         0: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
         1: return 32'd0;
         2: return $urandom;
         default: return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
      endcase
   endfunction

   task automatic send_frame(bit gaps);
      for (int s = 0; s < NUM_SLOTS; s++)
         send_item(s[3:0], (s == 0 && $urandom_range(0, 7) != 0) ?
                   $urandom_range(32'h1000, 32'h0100_0000) : rand_value(),
                   s == NUM_SLOTS - 1, gaps);
   endtask

   initial begin
      cycle_count = 0;
      items_sent = 0;
      settings_used = 0;
      stall_quiet = 0;
      req_valid = 0;
      req_data = '0;
      csr_valid = 0;
      csr_index = CSR_PLANE_A;
      csr_wdata = 0;
      reset = 1;
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: reset store gives divide error, then extremes and out-of-range slots
      send_item(4'd0, 32'd0, 1'b1, 1'b0);
      send_item(4'd0, 32'h7fffffff, 1'b0, 1'b0);
      send_item(4'd4, 32'h7fffffff, 1'b0, 1'b0);
      send_item(4'd5, 32'h7fffffff, 1'b0, 1'b0);
      send_item(4'd12, 32'h80000000, 1'b0, 1'b0);
      send_item(4'd10, 32'h7fffffff, 1'b0, 1'b0);
      send_item(4'd11, 32'h80000000, 1'b1, 1'b0);
      send_item(4'd15, 32'hffffffff, 1'b1, 1'b0);
      send_item(4'd13, 32'h12345678, 1'b1, 1'b0);
      set_plane(32'h7fffffff, 32'h80000000, 32'h80000000, 1'b1);
      send_item(4'd5, 32'h80000001, 1'b1, 1'b0);
      send_item(4'd1, 32'h80000000, 1'b0, 1'b0);
      send_item(4'd2, 32'h7fffffff, 1'b0, 1'b0);
      send_item(4'd3, 32'h00010000, 1'b0, 1'b0);
      send_item(4'd6, 32'hffff0000, 1'b0, 1'b0);
      send_item(4'd7, 32'h00008000, 1'b0, 1'b0);
      send_item(4'd8, 32'h80000000, 1'b0, 1'b0);
      send_item(4'd9, 32'h7fffffff, 1'b0, 1'b0);
      send_item(4'd14, 32'h0, 1'b1, 1'b0);
      send_item(4'd4, 32'h0, 1'b0, 1'b0);
      send_item(4'd5, 32'h0, 1'b1, 1'b0);
      set_plane(32'h80000000, 32'h7fffffff, 32'h7fffffff, 1'b0);
      send_item(4'd4, 32'h00020000, 1'b1, 1'b0);

      // random frames; phases change the plane and mode
      for (int ph = 0; ph < 4; ph++) begin
         set_plane(rand_value(), rand_value(), rand_value(), ph[0]);
         stall_quiet = (ph == 2);
         for (int f = 0; f < 4; f++) begin
            if ($urandom_range(0, 4) == 0)
               send_item(4'($urandom_range(0, 15)), $urandom,
                         1'($urandom_range(0, 1)), 1'b1);
            send_frame(ph != 2);
         end
         drain();
      end
      stall_quiet = 0;

      drain();
      $display("Covered %0d items over %0d plane settings, dense and discrete modes,",
               items_sent, settings_used);
      $display("zero divisors, saturation extremes and %0d checked results.", rows_seen);
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end
endmodule
